// ----- src/tlmpb_pkg.sv -----
package tlmpb_pkg;

   // fixed width of the page id fields on the ports
   localparam int PAGE_FIELD_BITS = 16;

   // placement codes
   localparam logic [1:0] PLACE_OLD  = 2'd0;
   localparam logic [1:0] PLACE_HOT  = 2'd1;
   localparam logic [1:0] PLACE_NONE = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic step;       // look up the request word, update lists, load result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hot_full;   // hot list tail occupied
      logic old_full;   // old list tail occupied
   } status_type;

endpackage

// ----- src/tlmpb_ctrl.sv -----
module tlmpb_ctrl
   import tlmpb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic ST_EMPTY = 1'b0;
   localparam logic ST_FULL  = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   // a new word may enter whenever the result register is empty or being drained
   assign req_stall = (state_ff == ST_FULL) && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_FULL);

   always_comb begin
      cmd = '0;
      cmd.step = accept;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_EMPTY: begin
            if (accept) state_in = ST_FULL;
         end
         ST_FULL: begin
            if (!rsp_stall && !accept) state_in = ST_EMPTY;
         end
         default: state_in = ST_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   // list fill is tracked in the datapath; nothing here depends on it
   logic unused_status;
   assign unused_status = status.hot_full ^ status.old_full;

endmodule

// ----- src/tlmpb_datapath.sv -----
module tlmpb_datapath
   import tlmpb_pkg::*;
#(
   parameter int PAGE_ID_BITS = 16,
   parameter int HOT_DEPTH    = 10,
   parameter int OLD_DEPTH    = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  logic [PAGE_FIELD_BITS-1:0] req_page_id,
   output logic                       rsp_found_old,
   output logic                       rsp_found_hot,
   output logic [1:0]                 rsp_placement,
   output logic                       rsp_evict_valid,
   output logic [PAGE_FIELD_BITS-1:0] rsp_evicted_page
);

   logic [PAGE_ID_BITS-1:0] hot_pages_ff [HOT_DEPTH];
   logic [PAGE_ID_BITS-1:0] hot_pages_in [HOT_DEPTH];
   logic [HOT_DEPTH-1:0]    hot_valid_ff;
   logic [HOT_DEPTH-1:0]    hot_valid_in;
   logic [PAGE_ID_BITS-1:0] old_pages_ff [OLD_DEPTH];
   logic [PAGE_ID_BITS-1:0] old_pages_in [OLD_DEPTH];
   logic [OLD_DEPTH-1:0]    old_valid_ff;
   logic [OLD_DEPTH-1:0]    old_valid_in;

   logic                       found_old_ff, found_old_in;
   logic                       found_hot_ff, found_hot_in;
   logic [1:0]                 placement_ff, placement_in;
   logic                       evict_valid_ff, evict_valid_in;
   logic [PAGE_FIELD_BITS-1:0] evicted_page_ff, evicted_page_in;

   logic [PAGE_ID_BITS-1:0]    id;
   logic [HOT_DEPTH-1:0]       hot_hit;
   logic [OLD_DEPTH-1:0]       old_hit;
   logic                       in_old, in_hot, push_hot, push_old;
   logic [PAGE_ID_BITS-1:0]    dropped;
   logic [PAGE_FIELD_BITS-1:0] dropped_field;

   generate
      if (PAGE_ID_BITS <= PAGE_FIELD_BITS) begin : g_narrow_id
         assign id = req_page_id[PAGE_ID_BITS-1:0];
         assign dropped_field = PAGE_FIELD_BITS'(dropped);
      end else begin : g_wide_id
         assign id = PAGE_ID_BITS'(req_page_id);
         assign dropped_field = dropped[PAGE_FIELD_BITS-1:0];
      end
   endgenerate

   always_comb begin
      for (int k = 0; k < HOT_DEPTH; k++) begin
         hot_hit[k] = hot_valid_ff[k] && (hot_pages_ff[k] == id);
      end
      for (int k = 0; k < OLD_DEPTH; k++) begin
         old_hit[k] = old_valid_ff[k] && (old_pages_ff[k] == id);
      end
   end

   assign in_old   = |old_hit;
   assign in_hot   = |hot_hit;
   assign push_hot = in_old && !in_hot;
   assign push_old = !in_old;

   assign status.hot_full = hot_valid_ff[HOT_DEPTH-1];
   assign status.old_full = old_valid_ff[OLD_DEPTH-1];

   always_comb begin
      hot_pages_in = hot_pages_ff;
      hot_valid_in = hot_valid_ff;
      old_pages_in = old_pages_ff;
      old_valid_in = old_valid_ff;
      dropped      = '0;
      evict_valid_in = 1'b0;
      placement_in   = PLACE_NONE;
      if (push_hot) begin
         placement_in   = PLACE_HOT;
         evict_valid_in = hot_valid_ff[HOT_DEPTH-1];
         if (hot_valid_ff[HOT_DEPTH-1]) dropped = hot_pages_ff[HOT_DEPTH-1];
         for (int k = 1; k < HOT_DEPTH; k++) begin
            hot_pages_in[k] = hot_pages_ff[k-1];
         end
         hot_pages_in[0] = id;
         hot_valid_in    = {hot_valid_ff[HOT_DEPTH-2:0], 1'b1};
      end else if (push_old) begin
         placement_in   = PLACE_OLD;
         evict_valid_in = old_valid_ff[OLD_DEPTH-1];
         if (old_valid_ff[OLD_DEPTH-1]) dropped = old_pages_ff[OLD_DEPTH-1];
         for (int k = 1; k < OLD_DEPTH; k++) begin
            old_pages_in[k] = old_pages_ff[k-1];
         end
         old_pages_in[0] = id;
         old_valid_in    = {old_valid_ff[OLD_DEPTH-2:0], 1'b1};
      end
      found_old_in    = in_old;
      found_hot_in    = in_hot;
      evicted_page_in = dropped_field;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hot_valid_ff <= '0;
         old_valid_ff <= '0;
      end else if (cmd.step) begin
         hot_valid_ff <= hot_valid_in;
         old_valid_ff <= old_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         hot_pages_ff    <= hot_pages_in;
         old_pages_ff    <= old_pages_in;
         found_old_ff    <= found_old_in;
         found_hot_ff    <= found_hot_in;
         placement_ff    <= placement_in;
         evict_valid_ff  <= evict_valid_in;
         evicted_page_ff <= evicted_page_in;
      end
   end

   assign rsp_found_old    = found_old_ff;
   assign rsp_found_hot    = found_hot_ff;
   assign rsp_placement    = placement_ff;
   assign rsp_evict_valid  = evict_valid_ff;
   assign rsp_evicted_page = evicted_page_ff;

endmodule

// ----- src/two_list_midpoint_page_buffer.sv -----
// Two-list midpoint page buffer: replacement policy of a buffer pool.
// Request channel (req_valid / req_stall / req_page_id) takes one page id per
// word. A page missing from the old list is pushed onto the old list's head;
// a page in the old list but not the hot list is pushed onto the hot list's
// head; a page in both changes nothing. A push into a full list drops its tail.
// Response channel (rsp_valid / rsp_stall / rsp_*) returns one word per
// request: hit flags, placement code and the dropped page, if any.
// Latency: the response is valid the cycle after the request is taken.
// Throughput: one request per cycle; the lookup compares every list entry in
// parallel and the selected list shifts by one slot in the same cycle.
// The single response register is refilled in the cycle it is drained.
// While rsp_stall holds a pending response, req_stall is raised and the
// lists do not change. Reset clears all occupancy and empties the response
// register; the lists start empty and no word is pending.
module two_list_midpoint_page_buffer
   import tlmpb_pkg::*;
#(
   parameter int BUFFER_SLOTS = 16,
   parameter int PAGE_ID_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [PAGE_FIELD_BITS-1:0] req_page_id,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_found_old,
   output logic                       rsp_found_hot,
   output logic [1:0]                 rsp_placement,
   output logic                       rsp_evict_valid,
   output logic [PAGE_FIELD_BITS-1:0] rsp_evicted_page
);

   localparam int HOT_DEPTH = (5 * BUFFER_SLOTS) / 8;
   localparam int OLD_DEPTH = (3 * BUFFER_SLOTS) / 8;

   cmd_type    cmd;
   status_type status;

   tlmpb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tlmpb_datapath #(
      .PAGE_ID_BITS (PAGE_ID_BITS),
      .HOT_DEPTH    (HOT_DEPTH),
      .OLD_DEPTH    (OLD_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_page_id      (req_page_id),
      .rsp_found_old    (rsp_found_old),
      .rsp_found_hot    (rsp_found_hot),
      .rsp_placement    (rsp_placement),
      .rsp_evict_valid  (rsp_evict_valid),
      .rsp_evicted_page (rsp_evicted_page)
   );

endmodule

// ----- src/tlmpb_checker.sv -----
module tlmpb_checker
   import tlmpb_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic                       rsp_found_old,
   input logic                       rsp_found_hot,
   input logic [1:0]                 rsp_placement,
   input logic                       rsp_evict_valid,
   input logic [PAGE_FIELD_BITS-1:0] rsp_evicted_page
);

   // no response word survives reset
   a_reset_empty: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_placement)
         && $stable(rsp_evicted_page) && $stable(rsp_evict_valid))
      else $error("stalled response changed");

   // placement agrees with the hit flags
   a_place_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_placement == PLACE_OLD && !rsp_found_old)
         || (rsp_placement == PLACE_HOT && rsp_found_old && !rsp_found_hot)
         || (rsp_placement == PLACE_NONE && rsp_found_old && rsp_found_hot))
      else $error("placement inconsistent with hit flags");

   // no push, no eviction; no eviction, zero page
   a_evict_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_placement == PLACE_NONE || !rsp_evict_valid)
         |-> !rsp_evict_valid && rsp_evicted_page == '0)
      else $error("eviction reported without a push");

   // an accepted request always yields a response word next cycle
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

endmodule

bind two_list_midpoint_page_buffer tlmpb_checker u_tlmpb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_found_old    (rsp_found_old),
   .rsp_found_hot    (rsp_found_hot),
   .rsp_placement    (rsp_placement),
   .rsp_evict_valid  (rsp_evict_valid),
   .rsp_evicted_page (rsp_evicted_page)
);
